@@ design/skvt_pkg.sv @@
// Package for the sorted key/value table: beat and entry types and operation codes.
// No dependencies; used by the table top level.
package skvt_pkg;

  // Operation codes carried in the func field.
  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_PUT    = 1'b1;

  // Width of the entry_count result field.
  localparam int unsigned COUNT_OUT_W = 5;

  // One input beat.
  typedef struct packed {
    logic               func;
    logic signed [31:0] key;
    logic        [31:0] value_in;
  } skvt_in_t;

  // One result beat.
  typedef struct packed {
    logic                   hit;
    logic [31:0]            value_out;
    logic                   dropped;
    logic [COUNT_OUT_W-1:0] entry_count;
  } skvt_out_t;

  // One stored table entry.
  typedef struct packed {
    logic signed [31:0] key;
    logic        [31:0] value;
  } skvt_entry_t;

endpackage

@@ design/skvt_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; used by the table top level for entry storage.
module skvt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/sorted_key_value_table.sv @@
// Sorted key/value table: a map of signed keys to value handles held in ascending key order.
// An item is taken only when the block is idle and its result is written to an output
// register. A lookup, an overwrite or a refused put runs a linear scan through the entry RAM,
// which reads one entry a cycle. An insert ends its scan at the first larger key and then
// moves every later entry up one slot, one per cycle, before it writes the new entry.
// A stalled result beat holds the block in its response state while the stall lasts.
// The entries live in one RAM with a registered read; only the control registers, the count
// among them, are reset. Depends on skvt_pkg and skvt_ram.
module sorted_key_value_table
  import skvt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  skvt_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output skvt_out_t out_data
);

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned ENT_W = $bits(skvt_entry_t);

  // Sequencer state codes.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_SHIFT  = 3'd2;
  localparam logic [2:0] ST_INSERT = 3'd3;
  localparam logic [2:0] ST_RESP   = 3'd4;

  logic [2:0]       state_r, state_nxt;
  skvt_in_t         req_r, req_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             issue_r, issue_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic             res_hit_r, res_hit_nxt;
  logic [31:0]      res_val_r, res_val_nxt;
  logic             res_drop_r, res_drop_nxt;
  logic             out_valid_r, out_valid_nxt;
  skvt_out_t        out_r, out_nxt;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  skvt_entry_t      ram_wdata;
  logic [ENT_W-1:0] ram_rdata;
  skvt_entry_t      rd_entry;
  logic             rd_issue;
  logic             key_ge;
  logic             key_eq;
  logic             scan_last;
  logic             tbl_full;
  logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

  skvt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (IDX_W'(idx_r)),
    .rd_data (ram_rdata)
  );

  assign rd_entry  = skvt_entry_t'(ram_rdata);
  assign key_ge    = $signed(rd_entry.key) >= $signed(req_r.key);
  assign key_eq    = rd_entry.key == req_r.key;
  assign scan_last = (CNT_W'(rd_idx_r) + CNT_W'(1)) == count_r;
  assign tbl_full  = count_r == CNT_W'(TABLE_DEPTH);
  assign count_ext = {{COUNT_OUT_W{1'b0}}, count_r};

  // A read goes out while the scan has entries left or the shift has moves left.
  always_comb begin
    case (state_r)
      ST_SCAN:  rd_issue = idx_r < count_r;
      ST_SHIFT: rd_issue = issue_r;
      default:  rd_issue = 1'b0;
    endcase
  end

  // Sequencer: scan for the key, then overwrite, shift and insert, or just report.
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    issue_nxt     = issue_r;
    rd_vld_nxt    = rd_issue;
    rd_idx_nxt    = IDX_W'(idx_r);
    pos_nxt       = pos_r;
    res_hit_nxt   = res_hit_r;
    res_val_nxt   = res_val_r;
    res_drop_nxt  = res_drop_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = rd_idx_r;
    ram_wdata     = '{key: req_r.key, value: req_r.value_in};

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt      = in_data;
          idx_nxt      = '0;
          res_hit_nxt  = 1'b0;
          res_val_nxt  = '0;
          res_drop_nxt = 1'b0;
          pos_nxt      = '0;
          if (count_r != '0) begin
            state_nxt = ST_SCAN;
          end else if (in_data.func == FUNC_PUT) begin
            state_nxt = ST_INSERT;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end

      ST_SCAN: begin
        if (rd_issue) begin
          idx_nxt = idx_r + CNT_W'(1);
        end
        // The first stored key at or above the request, or the last stored entry, ends the scan.
        if (rd_vld_r && (key_ge || scan_last)) begin
          rd_vld_nxt  = 1'b0;
          res_hit_nxt = key_eq;
          if (req_r.func == FUNC_LOOKUP) begin
            res_val_nxt = key_eq ? rd_entry.value : '0;
            state_nxt   = ST_RESP;
          end else if (key_eq) begin
            ram_we      = 1'b1;
            res_val_nxt = req_r.value_in;
            state_nxt   = ST_RESP;
          end else if (tbl_full) begin
            res_drop_nxt = 1'b1;
            state_nxt    = ST_RESP;
          end else if (!key_ge) begin
            pos_nxt   = IDX_W'(count_r);
            state_nxt = ST_INSERT;
          end else begin
            pos_nxt   = rd_idx_r;
            idx_nxt   = count_r - CNT_W'(1);
            issue_nxt = 1'b1;
            state_nxt = ST_SHIFT;
          end
        end
      end

      ST_SHIFT: begin
        // Move entries up one slot, from the top down to the insert position.
        if (issue_r) begin
          if (idx_r == CNT_W'(pos_r)) begin
            issue_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r - CNT_W'(1);
          end
        end
        if (rd_vld_r) begin
          ram_we    = 1'b1;
          ram_waddr = rd_idx_r + IDX_W'(1);
          ram_wdata = rd_entry;
          if (rd_idx_r == pos_r) begin
            state_nxt = ST_INSERT;
          end
        end
      end

      ST_INSERT: begin
        ram_we       = 1'b1;
        ram_waddr    = pos_r;
        count_nxt    = count_r + CNT_W'(1);
        res_hit_nxt  = 1'b0;
        res_val_nxt  = req_r.value_in;
        res_drop_nxt = 1'b0;
        state_nxt    = ST_RESP;
      end

      ST_RESP: begin
        // Load the output register once the previous result beat has left.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{hit: res_hit_r, value_out: res_val_r, dropped: res_drop_r,
                      entry_count: count_ext[COUNT_OUT_W-1:0]};
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      issue_r     <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      issue_r     <= issue_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    idx_r      <= idx_nxt;
    rd_idx_r   <= rd_idx_nxt;
    pos_r      <= pos_nxt;
    res_hit_r  <= res_hit_nxt;
    res_val_r  <= res_val_nxt;
    res_drop_r <= res_drop_nxt;
    out_r      <= out_nxt;
  end

  assign in_stall  = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // The count never goes past the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  // The entry RAM is written only while an item is being worked on.
  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_SCAN || state_r == ST_SHIFT || state_r == ST_INSERT))
    else $error("entry RAM written outside an operation");

  // An insert adds exactly one entry.
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_INSERT |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not advance the entry count");

  // An insert never happens into a full table.
  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_INSERT |-> !tbl_full)
    else $error("insert into a full table");
`endif

endmodule
